// ===== design/mbg_pkg.sv =====
// package: shared constants, field widths and codes of the maze backtracker generator
`timescale 1ns / 1ps

package mbg_pkg;

    // default geometry
    localparam int GRID_SIZE_DEF   = 32;
    localparam int STACK_DEPTH_DEF = 1024;

    // port field widths
    localparam int OP_W       = 1;
    localparam int ROLL_W     = 7;
    localparam int DIR_W      = 2;
    localparam int EVENT_W    = 2;
    localparam int COORD_IO_W = 5;
    localparam int STRAIGHT_W = 7;
    localparam int MARGIN_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int HEAD_W     = 3;
    localparam int NUM_DIRS   = 4;

    // register reset values
    localparam logic [STRAIGHT_W-1:0] STRAIGHT_RST  = 7'd16;
    localparam logic [MARGIN_W-1:0]   MARGIN_RST    = 2'd2;
    localparam logic [COORD_IO_W-1:0] START_COL_RST = 5'd15;
    localparam logic [COORD_IO_W-1:0] START_ROW_RST = 5'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd3;

    // operation codes
    localparam logic [OP_W-1:0] OP_RESTART = 1'b0;
    localparam logic [OP_W-1:0] OP_TRIAL   = 1'b1;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CARVED   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_BACK     = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FINISHED = 2'd3;

    // heading codes
    localparam logic [HEAD_W-1:0] HEAD_NONE  = 3'd0;
    localparam logic [HEAD_W-1:0] HEAD_UP    = 3'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 3'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 3'd3;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 3'd4;

    localparam logic [NUM_DIRS-1:0] ALL_BLOCKED = 4'hF;

    // blocked-set bit of a heading
    function automatic logic [NUM_DIRS-1:0] dir_bit(input logic [HEAD_W-1:0] head);
        logic [NUM_DIRS-1:0] res;
        res = '0;
        case (head)
            HEAD_UP:    res = 4'b0001;
            HEAD_DOWN:  res = 4'b0010;
            HEAD_LEFT:  res = 4'b0100;
            HEAD_RIGHT: res = 4'b1000;
            default:    res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/mbg_ram.sv =====
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module mbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/maze_backtracker_generator.sv =====
// top level: depth-first maze carver with row-organized grid memory and path stack memory
//
// Usage
//   Input channel (in_valid / in_stall) carries operation, roll and dir_pick. A restart
//   clears the grid, carves the start cell and pushes it; a trial tries one step of the
//   walker. Each item produces exactly one result on the output channel
//   (out_valid / out_stall): event_res plus the walker position after the item.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are taken at any
//   time; they are meant to be issued while no item is in flight.
// Sequencing
//   One item at a time: a trial on an empty stack goes straight to the handoff, a restart
//   writes the start cell first and a trial with no heading to test goes to the decision.
//   The window test reads and tests one grid row at a time (margin+1 rows up or down,
//   2*margin+1 left or right, no read off the grid), then decides, carves or pops and hands
//   off, paced by the grid row memory port; a new item is taken once the result is loaded.
// Reset
//   Grid rows are marked empty through per-row valid flags, so no clearing pass is run;
//   the stack is empty and the registers take their documented defaults.
// Stall
//   The result waits in the output register while out_stall is high; a finished item
//   waits in the handoff state for the register to free up before a new item is accepted.
`timescale 1ns / 1ps

module maze_backtracker_generator #(
    parameter int GRID_SIZE   = mbg_pkg::GRID_SIZE_DEF,
    parameter int STACK_DEPTH = mbg_pkg::STACK_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mbg_pkg::OP_W-1:0]        operation,
    input  logic [mbg_pkg::ROLL_W-1:0]      roll,
    input  logic [mbg_pkg::DIR_W-1:0]       dir_pick,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mbg_pkg::EVENT_W-1:0]     event_res,
    output logic [mbg_pkg::COORD_IO_W-1:0]  cell_col,
    output logic [mbg_pkg::COORD_IO_W-1:0]  cell_row,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import mbg_pkg::*;

    localparam int CW      = $clog2(GRID_SIZE);
    localparam int SW      = CW + 3;
    localparam int SA_W    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = 2 * CW;

    localparam logic [GRID_SIZE-1:0] ROW_ONES = '1;
    localparam logic [GRID_SIZE-1:0] ROW_ONE  = GRID_SIZE'(1);
    localparam logic [CW-1:0]        COORD_MAX = CW'(GRID_SIZE - 1);
    localparam logic signed [SW-1:0] COORD_MAX_S = SW'(GRID_SIZE - 1);
    localparam logic [DEPTH_W-1:0]   DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [SA_W-1:0]      STACK_TOP = SA_W'(STACK_DEPTH - 1);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_RESTART  = 10'b0000000010,
        ST_WIN_RD   = 10'b0000000100,
        ST_WIN_EV   = 10'b0000001000,
        ST_DECIDE   = 10'b0000010000,
        ST_CARVE_RD = 10'b0000100000,
        ST_CARVE_WR = 10'b0001000000,
        ST_POP_RD   = 10'b0010000000,
        ST_POP_WAIT = 10'b0100000000,
        ST_FINISH   = 10'b1000000000
    } state_t;

    // control registers
    state_t                 state_reg, state_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [CW-1:0]          walker_col_reg, walker_col_next;
    logic [CW-1:0]          walker_row_reg, walker_row_next;
    logic [HEAD_W-1:0]      heading_reg, heading_next;
    logic [NUM_DIRS-1:0]    blocked_reg, blocked_next;
    logic [GRID_SIZE-1:0]   row_valid_reg, row_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STRAIGHT_W-1:0]  straight_reg;
    logic [MARGIN_W-1:0]    margin_reg;
    logic [COORD_IO_W-1:0]  start_col_reg;
    logic [COORD_IO_W-1:0]  start_row_reg;

    // payload registers
    logic [CW-1:0]          r_cur_reg, r_cur_next;
    logic [CW-1:0]          r_end_reg, r_end_next;
    logic [GRID_SIZE-1:0]   mask_reg, mask_next;
    logic                   offgrid_reg, offgrid_next;
    logic [EVENT_W-1:0]     ev_reg, ev_next;
    logic [EVENT_W-1:0]     out_event_reg, out_event_next;
    logic [COORD_IO_W-1:0]  out_col_reg, out_col_next;
    logic [COORD_IO_W-1:0]  out_row_reg, out_row_next;

    // memory ports
    logic                   grid_we, grid_re;
    logic [CW-1:0]          grid_waddr, grid_raddr;
    logic [GRID_SIZE-1:0]   grid_wdata, grid_rdata;
    logic                   stk_we, stk_re;
    logic [SA_W-1:0]        stk_waddr, stk_raddr;
    logic [ENTRY_W-1:0]     stk_wdata, stk_rdata;

    // decode helpers
    logic                   in_xfer;
    logic [HEAD_W-1:0]      head_new;
    logic [NUM_DIRS-1:0]    head_bit;
    logic signed [SW-1:0]   xs, ys, ws;
    logic signed [SW-1:0]   r0, r1, c0, c1, hi_gap;
    logic [GRID_SIZE-1:0]   col_onehot;
    logic [GRID_SIZE-1:0]   row_cur_bits;
    logic                   row_hit;
    logic [CW-1:0]          sat_col, sat_row;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign cell_col  = out_col_reg;
    assign cell_row  = out_row_reg;

    // grid: one word per row, bit per column
    mbg_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // path stack: {row, col} per entry
    mbg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // heading chosen by this trial
    always_comb
    begin
        if (roll > straight_reg)
        begin
            head_new = HEAD_W'(dir_pick) + HEAD_W'(1);
        end
        else
        begin
            head_new = heading_reg;
        end
        head_bit = dir_bit(head_new);
    end

    // clearance window bounds for the new heading
    always_comb
    begin
        xs = signed'(SW'(walker_col_reg));
        ys = signed'(SW'(walker_row_reg));
        ws = signed'(SW'(margin_reg));
        r0 = ys - ws;
        r1 = ys + ws;
        c0 = xs - ws;
        c1 = xs + ws;
        case (head_new)
            HEAD_UP:
            begin
                r0 = ys - SW'(1) - ws;
                r1 = ys - SW'(1);
            end
            HEAD_DOWN:
            begin
                r0 = ys + SW'(1);
                r1 = ys + SW'(1) + ws;
            end
            HEAD_LEFT:
            begin
                c0 = xs - SW'(1) - ws;
                c1 = xs - SW'(1);
            end
            default:
            begin
                c0 = xs + SW'(1);
                c1 = xs + SW'(1) + ws;
            end
        endcase
        hi_gap = COORD_MAX_S - c1;
    end

    // saturated start cell
    always_comb
    begin
        sat_col = (int'(start_col_reg) > GRID_SIZE - 1) ? COORD_MAX : CW'(start_col_reg);
        sat_row = (int'(start_row_reg) > GRID_SIZE - 1) ? COORD_MAX : CW'(start_row_reg);
    end

    // row data seen by the window test, empty rows read as clear
    assign col_onehot   = ROW_ONE << walker_col_reg;
    assign row_cur_bits = row_valid_reg[r_cur_reg] ? grid_rdata : '0;
    assign row_hit      = |(row_cur_bits & mask_reg);

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        walker_col_next = walker_col_reg;
        walker_row_next = walker_row_reg;
        heading_next    = heading_reg;
        blocked_next    = blocked_reg;
        row_valid_next  = row_valid_reg;
        r_cur_next      = r_cur_reg;
        r_end_next      = r_end_reg;
        mask_next       = mask_reg;
        offgrid_next    = offgrid_reg;
        ev_next         = ev_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_event_next  = out_event_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        grid_we         = 1'b0;
        grid_re         = 1'b0;
        grid_waddr      = walker_row_reg;
        grid_raddr      = walker_row_reg;
        grid_wdata      = col_onehot;
        stk_we          = 1'b0;
        stk_re          = 1'b0;
        stk_waddr       = '0;
        stk_raddr       = SA_W'(depth_reg - DEPTH_W'(1));
        stk_wdata       = {walker_row_reg, walker_col_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == OP_RESTART)
                    begin
                        walker_col_next = sat_col;
                        walker_row_next = sat_row;
                        state_next      = ST_RESTART;
                    end
                    else if (depth_reg == '0)
                    begin
                        ev_next    = EV_FINISHED;
                        state_next = ST_FINISH;
                    end
                    else if (head_new == HEAD_NONE)
                    begin
                        heading_next = HEAD_NONE;
                        state_next   = ST_DECIDE;
                    end
                    else if ((blocked_reg & head_bit) != '0)
                    begin
                        heading_next = HEAD_NONE;
                        state_next   = ST_DECIDE;
                    end
                    else
                    begin
                        heading_next = head_new;
                        r_cur_next   = r0[CW-1:0];
                        r_end_next   = r1[CW-1:0];
                        offgrid_next = (r0 < 0) || (r1 > COORD_MAX_S) ||
                                       (c0 < 0) || (c1 > COORD_MAX_S);
                        mask_next    = (ROW_ONES << c0[CW-1:0]) & (ROW_ONES >> hi_gap[CW-1:0]);
                        state_next   = ST_WIN_RD;
                    end
                end
            end

            // clear all rows, carve the start cell and push it
            ST_RESTART:
            begin
                grid_we        = 1'b1;
                row_valid_next = ROW_ONE << walker_row_reg;
                stk_we         = 1'b1;
                stk_waddr      = '0;
                depth_next     = DEPTH_W'(1);
                heading_next   = HEAD_NONE;
                blocked_next   = '0;
                ev_next        = EV_NONE;
                state_next     = ST_FINISH;
            end

            // window row read, off-grid windows block at once
            ST_WIN_RD:
            begin
                if (offgrid_reg)
                begin
                    blocked_next = blocked_reg | dir_bit(heading_reg);
                    heading_next = HEAD_NONE;
                    state_next   = ST_DECIDE;
                end
                else
                begin
                    grid_re    = 1'b1;
                    grid_raddr = r_cur_reg;
                    state_next = ST_WIN_EV;
                end
            end

            ST_WIN_EV:
            begin
                if (row_hit)
                begin
                    blocked_next = blocked_reg | dir_bit(heading_reg);
                    heading_next = HEAD_NONE;
                    state_next   = ST_DECIDE;
                end
                else if (r_cur_reg == r_end_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    r_cur_next = r_cur_reg + CW'(1);
                    state_next = ST_WIN_RD;
                end
            end

            // carve, pop or report no move
            ST_DECIDE:
            begin
                if (heading_reg != HEAD_NONE)
                begin
                    case (heading_reg)
                        HEAD_UP:    walker_row_next = walker_row_reg - CW'(1);
                        HEAD_DOWN:  walker_row_next = walker_row_reg + CW'(1);
                        HEAD_LEFT:  walker_col_next = walker_col_reg - CW'(1);
                        default:    walker_col_next = walker_col_reg + CW'(1);
                    endcase
                    state_next = ST_CARVE_RD;
                end
                else if (blocked_reg == ALL_BLOCKED)
                begin
                    blocked_next = '0;
                    depth_next   = depth_reg - DEPTH_W'(1);
                    if (depth_reg == DEPTH_W'(1))
                    begin
                        ev_next    = EV_FINISHED;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
                else
                begin
                    ev_next    = EV_NONE;
                    state_next = ST_FINISH;
                end
            end

            ST_CARVE_RD:
            begin
                grid_re    = 1'b1;
                state_next = ST_CARVE_WR;
            end

            // row read-modify-write and push of the new cell
            ST_CARVE_WR:
            begin
                grid_we    = 1'b1;
                grid_wdata = (row_valid_reg[walker_row_reg] ? grid_rdata : '0) | col_onehot;
                row_valid_next[walker_row_reg] = 1'b1;
                stk_we     = 1'b1;
                if (depth_reg < DEPTH_FULL)
                begin
                    stk_waddr  = depth_reg[SA_W-1:0];
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                else
                begin
                    stk_waddr = STACK_TOP;
                end
                blocked_next = '0;
                ev_next      = EV_CARVED;
                state_next   = ST_FINISH;
            end

            // read the new stack top
            ST_POP_RD:
            begin
                stk_re     = 1'b1;
                state_next = ST_POP_WAIT;
            end

            ST_POP_WAIT:
            begin
                walker_row_next = stk_rdata[ENTRY_W-1:CW];
                walker_col_next = stk_rdata[CW-1:0];
                ev_next         = EV_BACK;
                state_next      = ST_FINISH;
            end

            // hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = ev_reg;
                    out_col_next   = COORD_IO_W'(walker_col_reg);
                    out_row_next   = COORD_IO_W'(walker_row_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            walker_col_reg <= '0;
            walker_row_reg <= '0;
            heading_reg    <= HEAD_NONE;
            blocked_reg    <= '0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            walker_col_reg <= walker_col_next;
            walker_row_reg <= walker_row_next;
            heading_reg    <= heading_next;
            blocked_reg    <= blocked_next;
            row_valid_reg  <= row_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_reg  <= STRAIGHT_RST;
            margin_reg    <= MARGIN_RST;
            start_col_reg <= START_COL_RST;
            start_row_reg <= START_ROW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STRAIGHT:  straight_reg  <= cfg_data[STRAIGHT_W-1:0];
                CFG_MARGIN:    margin_reg    <= cfg_data[MARGIN_W-1:0];
                CFG_START_COL: start_col_reg <= cfg_data[COORD_IO_W-1:0];
                CFG_START_ROW: start_row_reg <= cfg_data[COORD_IO_W-1:0];
                default:       straight_reg  <= straight_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        r_cur_reg     <= r_cur_next;
        r_end_reg     <= r_end_next;
        mask_reg      <= mask_next;
        offgrid_reg   <= offgrid_next;
        ev_reg        <= ev_next;
        out_event_reg <= out_event_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

endmodule

// ===== tb/maze_walk_checker.sv =====
// checker: watches the maze carver channels, predicts each walker result and compares it
`timescale 1ns / 1ps

module maze_walk_checker
    import mbg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [OP_W-1:0]        operation,
    input  logic [ROLL_W-1:0]      roll,
    input  logic [DIR_W-1:0]       dir_pick,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [EVENT_W-1:0]     event_res,
    input  logic [COORD_IO_W-1:0]  cell_col,
    input  logic [COORD_IO_W-1:0]  cell_row,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     expected_left
);

    localparam int GRID       = GRID_SIZE_DEF;
    localparam int CELLS      = GRID * GRID;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int STACK_MAX  = STACK_DEPTH_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [EVENT_W-1:0]    ev;
        logic [COORD_IO_W-1:0] col;
        logic [COORD_IO_W-1:0] row;
    } walk_result_t;

    // predicted maze state
    bit                     carved [CELLS];
    logic [CELL_W-1:0]      path_cells [STACK_MAX];
    int                     path_len;
    logic [COORD_IO_W-1:0]  walk_col;
    logic [COORD_IO_W-1:0]  walk_row;
    logic [HEAD_W-1:0]      heading;
    logic [NUM_DIRS-1:0]    blocked_set;

    // shadow of the configuration registers
    logic [STRAIGHT_W-1:0]  straight_reg;
    logic [MARGIN_W-1:0]    margin_reg;
    logic [COORD_IO_W-1:0]  start_col_reg;
    logic [COORD_IO_W-1:0]  start_row_reg;

    // walker results still owed by the block, oldest first
    walk_result_t expected_walk [$];

    function automatic logic [CELL_W-1:0] cell_of(logic [COORD_IO_W-1:0] col,
                                                  logic [COORD_IO_W-1:0] row);
        return CELL_W'(int'(row) * GRID + int'(col));
    endfunction

    function automatic logic [COORD_IO_W-1:0] clamp_coord(logic [COORD_IO_W-1:0] v);
        if (int'(v) > GRID - 1)
        begin
            return COORD_IO_W'(GRID - 1);
        end
        return v;
    endfunction

    // any carved or off-grid cell inside the rectangle
    function automatic bit area_taken(int c0, int c1, int r0, int r1);
        bit hit;
        hit = 1'b0;
        for (int r = r0; r <= r1; r++)
        begin
            for (int c = c0; c <= c1; c++)
            begin
                if (r < 0 || r >= GRID || c < 0 || c >= GRID)
                begin
                    hit = 1'b1;
                end
                else if (carved[r * GRID + c])
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // clearance window in the given heading, from the neighbour outward
    function automatic bit heading_closed(logic [HEAD_W-1:0] h);
        int x;
        int y;
        int w;
        bit res;
        x = int'(walk_col);
        y = int'(walk_row);
        w = int'(margin_reg);
        case (h)
            HEAD_UP:   res = area_taken(x - w, x + w, y - 1 - w, y - 1);
            HEAD_DOWN: res = area_taken(x - w, x + w, y + 1, y + 1 + w);
            HEAD_LEFT: res = area_taken(x - 1 - w, x - 1, y - w, y + w);
            default:   res = area_taken(x + 1, x + 1 + w, y - w, y + w);
        endcase
        return res;
    endfunction

    // one item through the carver: restart or one trial step
    task automatic carve_step(input logic [OP_W-1:0] op, input logic [ROLL_W-1:0] r,
                              input logic [DIR_W-1:0] pick, output walk_result_t res);
        logic [NUM_DIRS-1:0] dbit;
        logic [CELL_W-1:0]   spot;
        res.ev = EV_NONE;
        if (op == OP_RESTART)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                carved[i] = 1'b0;
            end
            walk_col = clamp_coord(start_col_reg);
            walk_row = clamp_coord(start_row_reg);
            spot = cell_of(walk_col, walk_row);
            carved[spot] = 1'b1;
            path_cells[0] = spot;
            path_len = 1;
            heading = HEAD_NONE;
            blocked_set = '0;
        end
        else if (path_len == 0)
        begin
            res.ev = EV_FINISHED;
        end
        else
        begin
            if (r > straight_reg)
            begin
                heading = {1'b0, pick} + 3'd1;
            end
            // drop a heading already known blocked, else test its window
            if (heading != HEAD_NONE)
            begin
                dbit = 4'b0001 << (heading - 3'd1);
                if (|(blocked_set & dbit))
                begin
                    heading = HEAD_NONE;
                end
                else if (heading_closed(heading))
                begin
                    blocked_set = blocked_set | dbit;
                    heading = HEAD_NONE;
                end
            end
            if (heading != HEAD_NONE)
            begin
                case (heading)
                    HEAD_UP:   walk_row = walk_row - 1'b1;
                    HEAD_DOWN: walk_row = walk_row + 1'b1;
                    HEAD_LEFT: walk_col = walk_col - 1'b1;
                    default:   walk_col = walk_col + 1'b1;
                endcase
                spot = cell_of(walk_col, walk_row);
                carved[spot] = 1'b1;
                // full stack: the top entry is replaced
                if (path_len < STACK_MAX)
                begin
                    path_cells[path_len] = spot;
                    path_len++;
                end
                else
                begin
                    path_cells[STACK_MAX - 1] = spot;
                end
                blocked_set = '0;
                res.ev = EV_CARVED;
            end
            else if (blocked_set == ALL_BLOCKED)
            begin
                // dead end: pop back along the path
                blocked_set = '0;
                path_len--;
                if (path_len == 0)
                begin
                    res.ev = EV_FINISHED;
                end
                else
                begin
                    spot = path_cells[path_len - 1];
                    walk_row = COORD_IO_W'(int'(spot) / GRID);
                    walk_col = COORD_IO_W'(int'(spot) % GRID);
                    res.ev = EV_BACK;
                end
            end
        end
        res.col = walk_col;
        res.row = walk_row;
    endtask

    // sample every transfer at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        walk_result_t predicted;
        walk_result_t seen;
        walk_result_t wanted;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                carved[i] = 1'b0;
            end
            path_len = 0;
            walk_col = '0;
            walk_row = '0;
            heading = HEAD_NONE;
            blocked_set = '0;
            straight_reg = STRAIGHT_RST;
            margin_reg = MARGIN_RST;
            start_col_reg = START_COL_RST;
            start_row_reg = START_ROW_RST;
            expected_walk.delete();
            fail_count = 0;
            expected_left = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STRAIGHT:  straight_reg = cfg_data[STRAIGHT_W-1:0];
                    CFG_MARGIN:    margin_reg = cfg_data[MARGIN_W-1:0];
                    CFG_START_COL: start_col_reg = cfg_data[COORD_IO_W-1:0];
                    CFG_START_ROW: start_row_reg = cfg_data[COORD_IO_W-1:0];
                    default:       ;
                endcase
            end
            // input transfer
            if (in_valid && !in_stall)
            begin
                carve_step(operation, roll, dir_pick, predicted);
                expected_walk.push_back(predicted);
            end
            // result transfer
            if (out_valid && !out_stall)
            begin
                seen = {event_res, cell_col, cell_row};
                if (expected_walk.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                    begin
                        $display("%0t: unexpected result event %0d col %0d row %0d",
                                 $time, seen.ev, seen.col, seen.row);
                    end
                end
                else
                begin
                    wanted = expected_walk.pop_front();
                    if (seen.ev != wanted.ev || seen.col != wanted.col ||
                        seen.row != wanted.row)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch event %0d/%0d col %0d/%0d row %0d/%0d %s",
                                     $time, wanted.ev, seen.ev, wanted.col, seen.col,
                                     wanted.row, seen.row, "(expected/actual)");
                        end
                    end
                end
            end
            expected_left = expected_walk.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// testbench top: drives the maze carver with directed and random items and gives the verdict
`timescale 1ns / 1ps

module tb_top;
    import mbg_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_IDLE     = 14;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int RESET_CYCLES = 5;

    // direction picks as carried on the input channel
    localparam logic [DIR_W-1:0] PICK_UP    = 2'd0;
    localparam logic [DIR_W-1:0] PICK_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] PICK_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] PICK_RIGHT = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [OP_W-1:0]         operation;
    logic [ROLL_W-1:0]       roll;
    logic [DIR_W-1:0]        dir_pick;
    logic                    out_valid;
    logic                    out_stall;
    logic [EVENT_W-1:0]      event_res;
    logic [COORD_IO_W-1:0]   cell_col;
    logic [COORD_IO_W-1:0]   cell_row;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    int                      fail_count;
    int                      expected_left;
    bit                      idle_on;
    int                      hold_cycles;

    always #HALF_PERIOD clk = ~clk;

    maze_backtracker_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .roll      (roll),
        .dir_pick  (dir_pick),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    maze_walk_checker walk_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .roll          (roll),
        .dir_pick      (dir_pick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .cell_col      (cell_col),
        .cell_row      (cell_row),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    // one item transfer; entered and left at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ROLL_W-1:0] r,
                             input logic [DIR_W-1:0] d);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = op;
        roll = r;
        dir_pick = d;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // stop offering items and wait for every owed result
    task automatic wait_idle();
        in_valid = 1'b0;
        while (expected_left != 0) @(negedge clk);
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // new setting, restart, then a random walk with the odd stray restart
    task automatic run_phase(input int trials, input logic [STRAIGHT_W-1:0] st,
                             input logic [MARGIN_W-1:0] mg,
                             input logic [COORD_IO_W-1:0] sc,
                             input logic [COORD_IO_W-1:0] sr);
        logic [ROLL_W-1:0] r_val;
        logic [DIR_W-1:0]  d_val;
        int                pick;
        wait_idle();
        write_reg(CFG_STRAIGHT, CFG_DATA_W'(st));
        write_reg(CFG_MARGIN, CFG_DATA_W'(mg));
        write_reg(CFG_START_COL, CFG_DATA_W'(sc));
        write_reg(CFG_START_ROW, CFG_DATA_W'(sr));
        send_item(OP_RESTART, ROLL_W'($urandom_range(0, 99)), DIR_W'($urandom_range(0, 3)));
        repeat (trials)
        begin
            r_val = ROLL_W'($urandom_range(0, 99));
            d_val = DIR_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                send_item(OP_RESTART, r_val, d_val);
            end
            else
            begin
                send_item(OP_TRIAL, r_val, d_val);
            end
        end
    endtask

    // result side: random stall per result, plus a long hold on request
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            n = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [STRAIGHT_W-1:0] st;
        logic [MARGIN_W-1:0]   mg;
        logic [COORD_IO_W-1:0] sc;
        logic [COORD_IO_W-1:0] sr;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_RESTART;
        roll = '0;
        dir_pick = PICK_UP;
        cfg_valid = 1'b0;
        cfg_index = CFG_STRAIGHT;
        cfg_data = '0;
        idle_on = 1'b1;
        hold_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // trial before any restart: walker never started
        send_item(OP_TRIAL, 7'd99, PICK_RIGHT);
        wait_idle();

        // corner start, no margin: carve a loop that boxes the walker in
        write_reg(CFG_STRAIGHT, 7'd50);
        write_reg(CFG_MARGIN, 7'd0);
        write_reg(CFG_START_COL, 7'd0);
        write_reg(CFG_START_ROW, 7'd0);
        send_item(OP_RESTART, 7'd28, PICK_RIGHT);
        send_item(OP_TRIAL, 7'd99, PICK_RIGHT);
        // roll equal to straightness keeps the heading
        send_item(OP_TRIAL, 7'd50, PICK_UP);
        send_item(OP_TRIAL, 7'd51, PICK_DOWN);
        send_item(OP_TRIAL, 7'd0, PICK_LEFT);
        send_item(OP_TRIAL, 7'd77, PICK_LEFT);
        send_item(OP_TRIAL, 7'd28, PICK_DOWN);
        send_item(OP_TRIAL, 7'd99, PICK_UP);
        send_item(OP_TRIAL, 7'd99, PICK_RIGHT);
        // now enclosed: each heading found blocked, then a pop back
        send_item(OP_TRIAL, 7'd99, PICK_UP);
        send_item(OP_TRIAL, 7'd99, PICK_UP);
        send_item(OP_TRIAL, 7'd50, PICK_RIGHT);
        send_item(OP_TRIAL, 7'd64, PICK_DOWN);
        send_item(OP_TRIAL, 7'd99, PICK_LEFT);
        send_item(OP_TRIAL, 7'd99, PICK_RIGHT);
        wait_idle();

        // widest margin in the corner: no way out, the pop empties the stack
        write_reg(CFG_MARGIN, 7'd3);
        send_item(OP_RESTART, 7'd0, PICK_UP);
        send_item(OP_TRIAL, 7'd99, PICK_UP);
        send_item(OP_TRIAL, 7'd99, PICK_DOWN);
        send_item(OP_TRIAL, 7'd99, PICK_LEFT);
        send_item(OP_TRIAL, 7'd99, PICK_RIGHT);
        send_item(OP_TRIAL, 7'd99, PICK_DOWN);

        // random walks under several settings
        run_phase(150, STRAIGHT_RST, MARGIN_RST, START_COL_RST, START_ROW_RST);
        idle_on = 1'b0;
        run_phase(150, 7'd0, 2'd0, 5'd31, 5'd31);
        idle_on = 1'b1;
        run_phase(40, 7'd100, 2'd3, 5'd0, 5'd31);
        // long output hold while items keep coming
        idle_on = 1'b0;
        hold_cycles = LONG_HOLD;
        run_phase(150, STRAIGHT_RST, 2'd1, 5'd16, 5'd16);
        for (int p = 0; p < 4; p++)
        begin
            idle_on = (p % 2 == 0);
            st = STRAIGHT_W'($urandom_range(0, 100));
            mg = MARGIN_W'($urandom_range(0, 3));
            sc = COORD_IO_W'($urandom_range(0, 31));
            sr = COORD_IO_W'($urandom_range(0, 31));
            run_phase(130, st, mg, sc, sr);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbg_pkg.sv
design/mbg_ram.sv
design/maze_backtracker_generator.sv
tb/maze_walk_checker.sv
tb/tb_top.sv
